@@ rtl/tea_counter_keystream_xor_defines.svh @@
// ----------------------------------------------------------------------------
// tea_counter_keystream_xor_defines
// Assertion macros shared by the keystream XOR block.
// ----------------------------------------------------------------------------
`ifndef TEA_COUNTER_KEYSTREAM_XOR_DEFINES_SVH
`define TEA_COUNTER_KEYSTREAM_XOR_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define TCKX_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tckx: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define TCKX_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tckx: next-cycle check failed");

`endif

@@ rtl/tckx_pkg.sv @@
// ----------------------------------------------------------------------------
// tckx_pkg
// Types, constants and key derivation for the TEA counter keystream block.
// ----------------------------------------------------------------------------
`default_nettype none

package tckx_pkg;

    typedef logic [31:0]       t_word;
    typedef logic [3:0][31:0]  t_key;

    localparam t_word TEA_DELTA = 32'h9e37_79b9;
    localparam t_word KEY_C0    = 32'h9e37_79b9;
    localparam t_word KEY_C1    = 32'h7f4a_7c15;
    localparam t_word KEY_C2    = 32'h3c6e_f372;
    localparam t_word KEY_C3    = 32'hbb67_ae85;
    localparam t_word V1_MASK   = 32'hdead_beef;

    // Configuration register indexes
    localparam logic [2:0] CFG_SALT_WORD0    = 3'd0;
    localparam logic [2:0] CFG_SALT_WORD1    = 3'd1;
    localparam logic [2:0] CFG_SALT_WORD2    = 3'd2;
    localparam logic [2:0] CFG_SALT_WORD3    = 3'd3;
    localparam logic [2:0] CFG_CIPHER_ENABLE = 3'd4;

    // One byte in flight through the round chain
    typedef struct packed {
        t_word       a;
        t_word       b;
        t_key        key;
        logic [7:0]  data;
        logic        last;
        logic [2:0]  pos;
    } t_item;

    function automatic t_key mix_block_key(input t_word idx, input t_key salt);
        t_key k;
        k[0] = salt[0] ^ KEY_C0 ^ idx;
        k[1] = salt[1] ^ KEY_C1 ^ (idx << 7);
        k[2] = salt[2] ^ KEY_C2 ^ (idx >> 3);
        k[3] = salt[3] ^ KEY_C3 ^ (idx << 13);
        return k;
    endfunction

endpackage

`default_nettype wire

@@ rtl/tckx_front.sv @@
// ----------------------------------------------------------------------------
// tckx_front
// Block framing, key derivation and counter; loads the first chain stage.
// ----------------------------------------------------------------------------
`default_nettype none

`include "tea_counter_keystream_xor_defines.svh"

module tckx_front
    import tckx_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_en,
    input  wire logic        i_accept,
    input  wire logic [7:0]  i_data_byte,
    input  wire t_word       i_block_index,
    input  wire logic        i_last_byte,
    input  wire t_key        i_salt,
    output logic             o_valid,
    output t_item            o_item
);

    logic        r_block_open;
    logic [2:0]  r_pos;
    t_word       r_ctr;
    t_key        r_key;
    logic        r_valid;
    t_item       r_item;

    logic        first;
    t_key        key_f;
    logic [2:0]  pos_f;
    t_word       ctr_f;
    logic        n_block_open;
    logic [2:0]  n_pos;
    t_word       n_ctr;
    t_item       n_item;

    always_comb begin
        first        = !r_block_open;
        key_f        = first ? mix_block_key(i_block_index, i_salt) : r_key;
        pos_f        = first ? 3'd0 : r_pos;
        ctr_f        = first ? 32'd0 : r_ctr;
        n_block_open = !i_last_byte;
        n_pos        = pos_f + 3'd1;
        // a new keystream word starts at each eighth byte
        n_ctr        = (pos_f == 3'd0) ? ctr_f + 32'd1 : ctr_f;
        n_item.a     = ctr_f;
        n_item.b     = ctr_f ^ V1_MASK;
        n_item.key   = key_f;
        n_item.data  = i_data_byte;
        n_item.last  = i_last_byte;
        n_item.pos   = pos_f;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_block_open <= 1'b0;
            r_pos        <= 3'd0;
            r_ctr        <= '0;
            r_key        <= '0;
            r_valid      <= 1'b0;
        end else begin
            if (i_accept) begin
                r_block_open <= n_block_open;
                r_pos        <= n_pos;
                r_ctr        <= n_ctr;
                r_key        <= key_f;
            end
            if (i_en) begin
                r_valid <= i_accept;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_item <= n_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

    `TCKX_ASSERT_NEXT(a_first_byte_counter, i_clk, i_rst_n,
        i_accept && !r_block_open, r_ctr == 32'd1)
    `TCKX_ASSERT_NOW(a_accept_needs_advance, i_clk, i_rst_n, i_accept, i_en)

endmodule

`default_nettype wire

@@ rtl/tckx_cell.sv @@
// ----------------------------------------------------------------------------
// tckx_cell
// One half of a TEA round: updates one word of the pair and hands it on.
// ----------------------------------------------------------------------------
`default_nettype none

module tckx_cell
    import tckx_pkg::*;
#(
    parameter logic [31:0] SUM  = 32'h9e37_79b9,
    parameter bit          SIDE = 1'b0
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_en,
    input  wire logic   i_valid,
    input  wire t_item  i_item,
    output logic        o_valid,
    output t_item       o_item
);

    logic   r_valid;
    t_item  r_item;
    t_word  src;
    t_word  ka;
    t_word  kb;
    t_word  mix;
    t_item  n_item;

    always_comb begin
        if (SIDE == 1'b0) begin
            src = i_item.b;
            ka  = i_item.key[0];
            kb  = i_item.key[1];
        end else begin
            src = i_item.a;
            ka  = i_item.key[2];
            kb  = i_item.key[3];
        end
        mix    = ((src << 4) + ka) ^ (src + SUM) ^ ((src >> 5) + kb);
        n_item = i_item;
        if (SIDE == 1'b0) begin
            n_item.a = i_item.a + mix;
        end else begin
            n_item.b = i_item.b + mix;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_item <= n_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

`default_nettype wire

@@ rtl/tckx_out.sv @@
// ----------------------------------------------------------------------------
// tckx_out
// Keystream byte select and XOR, output register with skid stage.
// ----------------------------------------------------------------------------
`default_nettype none

`include "tea_counter_keystream_xor_defines.svh"

module tckx_out
    import tckx_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_valid,
    input  wire t_item  i_item,
    input  wire logic   i_cipher_enable,
    input  wire logic   i_stall,
    output logic        o_en,
    output logic        o_valid,
    output logic [7:0]  o_data_out,
    output logic        o_last_out
);

    logic [63:0] r_ks_word;
    logic        r_out_valid;
    logic [7:0]  r_out_data;
    logic        r_out_last;
    logic        r_skid_full;
    logic [7:0]  r_skid_data;
    logic        r_skid_last;

    logic [63:0] word;
    logic [7:0]  ks_byte;
    logic [7:0]  res_data;
    logic        arrive;
    logic        take;

    always_comb begin
        // the first byte of each group carries the fresh word
        word     = (i_item.pos == 3'd0) ? {i_item.b, i_item.a} : r_ks_word;
        ks_byte  = word[{i_item.pos, 3'b000} +: 8];
        res_data = i_cipher_enable ? (i_item.data ^ ks_byte) : i_item.data;
        arrive   = i_valid && !r_skid_full;
        take     = r_out_valid && !i_stall;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ks_word   <= '0;
            r_out_valid <= 1'b0;
            r_skid_full <= 1'b0;
        end else begin
            if (arrive && (i_item.pos == 3'd0)) begin
                r_ks_word <= {i_item.b, i_item.a};
            end
            if (r_skid_full) begin
                if (take) begin
                    r_skid_full <= 1'b0;
                end
            end else if (arrive) begin
                if (!r_out_valid || take) begin
                    r_out_valid <= 1'b1;
                end else begin
                    r_skid_full <= 1'b1;
                end
            end else if (take) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_full) begin
            if (take) begin
                r_out_data <= r_skid_data;
                r_out_last <= r_skid_last;
            end
        end else if (arrive) begin
            if (!r_out_valid || take) begin
                r_out_data <= res_data;
                r_out_last <= i_item.last;
            end else begin
                r_skid_data <= res_data;
                r_skid_last <= i_item.last;
            end
        end
    end

    assign o_en       = !r_skid_full;
    assign o_valid    = r_out_valid;
    assign o_data_out = r_out_data;
    assign o_last_out = r_out_last;

    `TCKX_ASSERT_NOW(a_skid_needs_out, i_clk, i_rst_n, r_skid_full, r_out_valid)
    `TCKX_ASSERT_NEXT(a_skid_holds, i_clk, i_rst_n, r_skid_full && !take, r_skid_full)
    `TCKX_ASSERT_NEXT(a_take_frees_skid, i_clk, i_rst_n, r_skid_full && take,
        !r_skid_full && r_out_valid)

endmodule

`default_nettype wire

@@ rtl/tea_counter_keystream_xor.sv @@
// ----------------------------------------------------------------------------
// tea_counter_keystream_xor
// Counter-mode TEA keystream XOR over a byte stream, one round half per cell.
// ----------------------------------------------------------------------------
//  channel   direction  handshake                     payload
//  input     in         i_valid / o_stall             i_data_byte, i_block_index,
//                                                     i_last_byte
//  output    out        o_valid / i_stall             o_data_out, o_last_out
//  config    in         i_cfg_valid / o_cfg_ready     i_cfg_index, i_cfg_data
//
//  One byte per cycle while the output is not stalled; each byte passes the front
//  stage, the chain of 2*ROUNDS round-half cells and the output register.
//  Every byte walks the whole chain; only the word of each group's first byte is kept.
//  Reset (synchronous, active low) clears framing, counter, key, valids and the
//  configuration registers. A byte that reaches a stalled output fills the skid
//  stage, which then holds the chain and raises o_stall while it stays full.
// ----------------------------------------------------------------------------
`default_nettype none

module tea_counter_keystream_xor
    import tckx_pkg::*;
#(
    parameter int ROUNDS = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic [31:0] i_block_index,
    input  wire logic        i_last_byte,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [7:0]       o_data_out,
    output logic             o_last_out,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [31:0] i_cfg_data
);

    localparam int CELLS = 2 * ROUNDS;

    t_key   r_salt;
    logic   r_cipher_enable;
    logic   en;
    logic   accept;
    logic   pipe_valid [0:CELLS];
    t_item  pipe_item  [0:CELLS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_salt          <= '0;
            r_cipher_enable <= 1'b0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_SALT_WORD0:    r_salt[0]       <= i_cfg_data;
                CFG_SALT_WORD1:    r_salt[1]       <= i_cfg_data;
                CFG_SALT_WORD2:    r_salt[2]       <= i_cfg_data;
                CFG_SALT_WORD3:    r_salt[3]       <= i_cfg_data;
                CFG_CIPHER_ENABLE: r_cipher_enable <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;
    assign o_stall     = !en;
    assign accept      = i_valid && en;

    tckx_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_en          (en),
        .i_accept      (accept),
        .i_data_byte   (i_data_byte),
        .i_block_index (i_block_index),
        .i_last_byte   (i_last_byte),
        .i_salt        (r_salt),
        .o_valid       (pipe_valid[0]),
        .o_item        (pipe_item[0])
    );

    for (genvar g = 0; g < CELLS; g++) begin : g_cell
        localparam logic [63:0] SUM_FULL = 64'(TEA_DELTA) * 64'((g / 2) + 1);
        tckx_cell #(
            .SUM  (SUM_FULL[31:0]),
            .SIDE ((g % 2) == 1)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (pipe_valid[g]),
            .i_item  (pipe_item[g]),
            .o_valid (pipe_valid[g+1]),
            .o_item  (pipe_item[g+1])
        );
    end

    tckx_out u_out (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (pipe_valid[CELLS]),
        .i_item          (pipe_item[CELLS]),
        .i_cipher_enable (r_cipher_enable),
        .i_stall         (i_stall),
        .o_en            (en),
        .o_valid         (o_valid),
        .o_data_out      (o_data_out),
        .o_last_out      (o_last_out)
    );

endmodule

`default_nettype wire
